[rtl/jsu_pkg.sv]
// Shared types, constants and a helper function for the JSON string unescape block.
package jsu_pkg;

  // Default depth of the command queue between front and back.
  localparam int unsigned FifoDepth = 4;

  // Character codes seen in a string body.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerU    = 8'h75;

  // Control bytes produced by the single-letter escapes.
  localparam logic [7:0] ByteLf = 8'h0A;
  localparam logic [7:0] ByteHt = 8'h09;
  localparam logic [7:0] ByteCr = 8'h0D;
  localparam logic [7:0] ByteBs = 8'h08;
  localparam logic [7:0] ByteFf = 8'h0C;

  // UTF-8 encoding constants.
  localparam logic [15:0] Utf8Lim1 = 16'h0080;
  localparam logic [15:0] Utf8Lim2 = 16'h0800;
  localparam logic [7:0]  Utf8Lead2 = 8'hC0;
  localparam logic [7:0]  Utf8Lead3 = 8'hE0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;

  // Result counts per command.
  localparam logic [1:0] NumRes1 = 2'd1;
  localparam logic [1:0] NumRes2 = 2'd2;
  localparam logic [1:0] NumRes3 = 2'd3;

  // Decoder mode.
  typedef enum logic [2:0] {
    MODE_TEXT = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_HEX1 = 3'd2,
    MODE_HEX2 = 3'd3,
    MODE_HEX3 = 3'd4,
    MODE_HEX4 = 3'd5
  } mode_e;

  // Error codes reported on a result.
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_UNTERM_STR  = 3'd1,
    ERR_UNTERM_ESC  = 3'd2,
    ERR_BAD_UNICODE = 3'd3,
    ERR_BAD_ESCAPE  = 3'd4
  } err_e;

  // One queued command: up to three result bytes, or one end/error result.
  typedef struct packed {
    logic [1:0]      n_res;
    logic            has_byte;
    logic [2:0][7:0] bytes;
    logic            done;
    err_e            err;
  } cmd_t;

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

[rtl/jsu_front.sv]
// Front end: accepts string bytes, tracks the escape state and issues commands.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    char_byte_i,
  input  logic          no_more_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output jsu_pkg::cmd_t q_cmd_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [15:0]    cp_q, cp_d;
  logic           accept;
  logic [4:0]     hv;
  logic [15:0]    cp_new;
  logic           push;
  jsu_pkg::cmd_t  cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hv         = jsu_pkg::hex_value(char_byte_i);
  assign cp_new     = {cp_q[11:0], hv[3:0]};

  // Next decoder state
  always_comb begin
    mode_d = mode_q;
    cp_d   = cp_q;
    if (accept) begin
      mode_d = jsu_pkg::MODE_TEXT;
      cp_d   = 16'd0;
      if (!no_more_i) begin
        case (mode_q)
          jsu_pkg::MODE_TEXT: begin
            if (char_byte_i == jsu_pkg::ChBackslash) begin
              mode_d = jsu_pkg::MODE_ESC;
            end
          end
          jsu_pkg::MODE_ESC: begin
            if (char_byte_i == jsu_pkg::ChLowerU) begin
              mode_d = jsu_pkg::MODE_HEX1;
            end
          end
          jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3: begin
            if (hv[4]) begin
              mode_d = jsu_pkg::mode_e'(mode_q + 3'd1);
              cp_d   = cp_new;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Build the command for the accepted byte
  always_comb begin
    push = 1'b0;
    cmd  = '0;
    cmd.n_res = jsu_pkg::NumRes1;
    if (no_more_i) begin
      push = 1'b1;
      case (mode_q)
        jsu_pkg::MODE_TEXT: cmd.err = jsu_pkg::ERR_UNTERM_STR;
        jsu_pkg::MODE_ESC:  cmd.err = jsu_pkg::ERR_UNTERM_ESC;
        default:            cmd.err = jsu_pkg::ERR_BAD_UNICODE;
      endcase
    end else begin
      case (mode_q)
        jsu_pkg::MODE_ESC: begin
          push         = 1'b1;
          cmd.has_byte = 1'b1;
          case (char_byte_i)
            jsu_pkg::ChQuote:     cmd.bytes[0] = jsu_pkg::ChQuote;
            jsu_pkg::ChBackslash: cmd.bytes[0] = jsu_pkg::ChBackslash;
            jsu_pkg::ChSlash:     cmd.bytes[0] = jsu_pkg::ChSlash;
            jsu_pkg::ChLowerN:    cmd.bytes[0] = jsu_pkg::ByteLf;
            jsu_pkg::ChLowerT:    cmd.bytes[0] = jsu_pkg::ByteHt;
            jsu_pkg::ChLowerR:    cmd.bytes[0] = jsu_pkg::ByteCr;
            jsu_pkg::ChLowerB:    cmd.bytes[0] = jsu_pkg::ByteBs;
            jsu_pkg::ChLowerF:    cmd.bytes[0] = jsu_pkg::ByteFf;
            jsu_pkg::ChLowerU: begin
              push         = 1'b0;
              cmd.has_byte = 1'b0;
            end
            default: begin
              cmd.has_byte = 1'b0;
              cmd.err      = jsu_pkg::ERR_BAD_ESCAPE;
            end
          endcase
        end
        jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3,
        jsu_pkg::MODE_HEX4: begin
          if (!hv[4]) begin
            push    = 1'b1;
            cmd.err = jsu_pkg::ERR_BAD_UNICODE;
          end else if (mode_q == jsu_pkg::MODE_HEX4) begin
            push         = 1'b1;
            cmd.has_byte = 1'b1;
            if (cp_new < jsu_pkg::Utf8Lim1) begin
              cmd.bytes[0] = cp_new[7:0];
            end else if (cp_new < jsu_pkg::Utf8Lim2) begin
              cmd.n_res    = jsu_pkg::NumRes2;
              cmd.bytes[0] = jsu_pkg::Utf8Lead2 | {3'd0, cp_new[10:6]};
              cmd.bytes[1] = jsu_pkg::Utf8Cont | {2'd0, cp_new[5:0]};
            end else begin
              cmd.n_res    = jsu_pkg::NumRes3;
              cmd.bytes[0] = jsu_pkg::Utf8Lead3 | {4'd0, cp_new[15:12]};
              cmd.bytes[1] = jsu_pkg::Utf8Cont | {2'd0, cp_new[11:6]};
              cmd.bytes[2] = jsu_pkg::Utf8Cont | {2'd0, cp_new[5:0]};
            end
          end
        end
        default: begin
          // Text mode: quote ends the string, backslash opens an escape
          if (char_byte_i == jsu_pkg::ChQuote) begin
            push     = 1'b1;
            cmd.done = 1'b1;
          end else if (char_byte_i != jsu_pkg::ChBackslash) begin
            push         = 1'b1;
            cmd.has_byte = 1'b1;
            cmd.bytes[0] = char_byte_i;
          end
        end
      endcase
    end
  end

  assign q_push_o = accept && push;
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_TEXT;
      cp_q   <= 16'd0;
    end else begin
      mode_q <= mode_d;
      cp_q   <= cp_d;
    end
  end

`ifndef SYNTHESIS
  // Code point is clear whenever no \u escape is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == jsu_pkg::MODE_TEXT || mode_q == jsu_pkg::MODE_ESC) |-> cp_q == 16'd0)
    else $error("code point not clear outside a unicode escape");
`endif

endmodule

[rtl/jsu_fifo.sv]
// Short command queue between the front and back ends.
module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::FifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output jsu_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsu_pkg::cmd_t         mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into a full command queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("command queue occupancy out of range");
`endif

endmodule

[rtl/jsu_back.sv]
// Back end: expands queued commands into result transfers through an output register.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  jsu_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          byte_valid_o,
  output logic          last_o,
  output logic          string_done_o,
  output logic [2:0]    error_code_o
);

  logic [1:0]     idx_q, idx_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q;
  logic           byte_valid_q, last_q, done_q;
  jsu_pkg::err_e  err_q;
  logic           load, is_last;
  logic [7:0]     sel_byte;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == head_i.n_res - 2'd1);
  assign pop_o   = load && is_last;

  // Pick the byte of the current command
  always_comb begin
    case (idx_q)
      2'd1:    sel_byte = head_i.bytes[1];
      2'd2:    sel_byte = head_i.bytes[2];
      default: sel_byte = head_i.bytes[0];
    endcase
  end

  // Advance the result index and the output valid
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = is_last ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload until its transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= head_i.has_byte ? sel_byte : 8'd0;
      byte_valid_q <= head_i.has_byte;
      last_q       <= is_last;
      done_q       <= head_i.done;
      err_q        <= head_i.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign last_o        = last_q;
  assign string_done_o = done_q;
  assign error_code_o  = err_q;

`ifndef SYNTHESIS
  // A partly expanded command stays at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q != 2'd0 |-> head_valid_i)
    else $error("queue head lost in the middle of a multi-byte command");
`endif

endmodule

[rtl/json_string_unescape.sv]
// Top level of the JSON string body decoder with UTF-8 output for unicode escapes.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------------------
//  input   | in        | in_valid_i / in_ready_o   | char_byte_i, no_more_i
//  output  | out       | out_valid_o / out_ready_i | out_byte_o, byte_valid_o, last_o,
//          |           |                           | string_done_o, error_code_o
//
// One input byte is taken per cycle while the command queue has room.
// Each command leaves as one to three result transfers, one per cycle while out_ready_i is high.
// First result passes through the command queue and then the output register
// before it is valid on the output.
// rst_ni clears the decoder state, the queue occupancy and the output valid.
// A stalled output fills the queue; the input then stalls on a full queue.
module json_string_unescape #(
  parameter int unsigned FifoDepth = jsu_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       no_more_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       last_o,
  output logic       string_done_o,
  output logic [2:0] error_code_o
);

  logic          q_push, q_full, q_pop, q_head_valid;
  jsu_pkg::cmd_t q_cmd, q_head;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .no_more_i   (no_more_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd)
  );

  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (q_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_head_valid),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_o        (last_o),
    .string_done_o (string_done_o),
    .error_code_o  (error_code_o)
  );

endmodule
